FILE: hw/rtl/lhr_pkg.sv
// Shared types, sizes and codes for the line history ring.
package lhr_pkg;

  localparam int HIST_DEPTH   = 256;
  localparam int RECALL_LIMIT = 64;
  localparam int CHAR_W       = 8;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int ULEN_W       = HIST_AW + 1;
  localparam int CNT_W        = $clog2(RECALL_LIMIT + 1);

  typedef logic [HIST_AW-1:0] hist_addr_t;
  typedef logic [ULEN_W-1:0]  ulen_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam ulen_t ULEN_FULL = ULEN_W'(HIST_DEPTH);
  localparam cnt_t  CNT_LIMIT = CNT_W'(RECALL_LIMIT);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_PREV   = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    char_t      char_in;
  } lhr_in_t;

  typedef struct packed {
    logic  found;
    logic  has_char;
    char_t char_out;
    logic  last;
  } lhr_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_CHAR,
    S_APP_SEP,
    S_PREV_STEP,
    S_PREV_CHK,
    S_NEXT_CHK,
    S_STR_CHK,
    S_STR_LAST,
    S_FAIL
  } lhr_state_t;

endpackage

FILE: hw/rtl/lhr_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module lhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/line_history_ring.sv
// Top level of the line history ring: control sequencer around the history RAM.
//
// Command history held as a ring of zero-terminated strings in one RAM of
// HIST_DEPTH bytes. An append item writes its character and gives no result;
// one that ends a string with a zero also writes a separator after it.
// A recall-previous item visits the ring backward, one entry at a time,
// until it meets a separator; a recall-next item visits forward past the
// current string. Either then streams the string at one character per
// cycle while the output is not stalled, at most RECALL_LIMIT characters;
// the final result carries last. A recall that cannot move the read
// pointer gives a single result with found low. The RAM has a single read
// port with registered read data.
// Output stall simply lengthens a recall; one result waits in the output
// register while the sequencer fetches the next character. The RAM is not
// cleared: recalling text that was never appended returns arbitrary bytes.
module line_history_ring import lhr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lhr_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output lhr_out_t out_item
);

  function automatic hist_addr_t ring_next(hist_addr_t x, ulen_t ul);
    ulen_t xi;
    xi = {1'b0, x} + ULEN_W'(1);
    return (xi == ul) ? '0 : x + HIST_AW'(1);
  endfunction

  function automatic hist_addr_t ring_prev(hist_addr_t x, ulen_t ul);
    ulen_t top;
    top = ul - ULEN_W'(1);
    return (x == '0) ? top[HIST_AW-1:0] : x - HIST_AW'(1);
  endfunction

  function automatic lhr_out_t mk_out(logic f, logic h, char_t c, logic l);
    lhr_out_t o;
    o.found    = f;
    o.has_char = h;
    o.char_out = c;
    o.last     = l;
    return o;
  endfunction

  lhr_state_t state_r, state_nxt;
  hist_addr_t wp_r, wp_nxt;
  hist_addr_t rp_r, rp_nxt;
  ulen_t      ulen_r, ulen_nxt;
  hist_addr_t scan_r, scan_nxt;
  ulen_t      steps_r, steps_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       pend_v_r, pend_v_nxt;
  char_t      pend_c_r, pend_c_nxt;
  char_t      char_r, char_nxt;
  logic       out_valid_r, out_valid_nxt;
  lhr_out_t   out_item_r, out_item_nxt;

  logic       ram_we;
  hist_addr_t ram_waddr;
  char_t      ram_wdata;
  logic       ram_re;
  hist_addr_t ram_raddr;
  char_t      ram_rdata;

  logic       out_free;
  logic       emit;
  lhr_out_t   emit_item;
  ulen_t      wp_inc;
  ulen_t      ulen_cand;
  hist_addr_t wp_wrap;
  hist_addr_t step_addr;
  cnt_t       cnt_inc;

  lhr_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign wp_inc    = {1'b0, wp_r} + ULEN_W'(1);
  assign ulen_cand = (wp_inc + ULEN_W'(1) > ULEN_FULL) ? ULEN_FULL : wp_inc + ULEN_W'(1);
  assign wp_wrap   = (wp_inc == ULEN_FULL) ? '0 : wp_r + HIST_AW'(1);
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    ulen_nxt   = ulen_r;
    scan_nxt   = scan_r;
    steps_nxt  = steps_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_c_nxt = pend_c_r;
    char_nxt   = char_r;
    ram_we     = 1'b0;
    ram_waddr  = wp_r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = scan_r;
    emit       = 1'b0;
    emit_item  = '0;
    step_addr  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_item.op == OP_APPEND) begin
            char_nxt  = in_item.char_in;
            state_nxt = S_APP_CHAR;
            if (ulen_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              wp_nxt    = HIST_AW'(1);
              rp_nxt    = HIST_AW'(1);
            end
          end else if (in_item.op == OP_PREV) begin
            if (ulen_r == '0) begin
              state_nxt = S_FAIL;
            end else begin
              scan_nxt  = ring_prev(rp_r, ulen_r);
              steps_nxt = '0;
              state_nxt = S_PREV_STEP;
            end
          end else if (in_item.op == OP_NEXT) begin
            if (ulen_r == '0 || rp_r == wp_r) begin
              state_nxt = S_FAIL;
            end else begin
              scan_nxt  = rp_r;
              steps_nxt = '0;
              ram_re    = 1'b1;
              ram_raddr = rp_r;
              state_nxt = S_NEXT_CHK;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_APP_CHAR: begin
        ram_we    = 1'b1;
        ram_waddr = wp_r;
        ram_wdata = char_r;
        wp_nxt    = wp_wrap;
        if (ulen_r < ULEN_FULL) begin
          ulen_nxt = ulen_cand;
        end
        if (char_r == '0) begin
          rp_nxt    = wp_wrap;
          state_nxt = S_APP_SEP;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_APP_SEP: begin
        ram_we    = 1'b1;
        ram_waddr = wp_r;
        state_nxt = S_IDLE;
      end

      S_PREV_STEP: begin
        if (steps_r >= ulen_r) begin
          state_nxt = S_FAIL;
        end else begin
          step_addr = ring_prev(scan_r, ulen_r);
          steps_nxt = steps_r + ULEN_W'(1);
          scan_nxt  = step_addr;
          if (step_addr == wp_r) begin
            state_nxt = S_FAIL;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = step_addr;
            state_nxt = S_PREV_CHK;
          end
        end
      end

      S_PREV_CHK, S_NEXT_CHK: begin
        step_addr = ring_next(scan_r, ulen_r);
        if (ram_rdata == '0) begin
          rp_nxt     = step_addr;
          scan_nxt   = step_addr;
          ram_re     = 1'b1;
          ram_raddr  = step_addr;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_STR_CHK;
        end else if (state_r == S_PREV_CHK) begin
          state_nxt = S_PREV_STEP;
        end else if (steps_r >= ulen_r) begin
          state_nxt = S_FAIL;
        end else begin
          steps_nxt = steps_r + ULEN_W'(1);
          scan_nxt  = step_addr;
          ram_re    = 1'b1;
          ram_raddr = step_addr;
        end
      end

      S_STR_CHK: begin
        step_addr = ring_next(scan_r, ulen_r);
        if (ram_rdata == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_item = pend_v_r ? mk_out(1'b1, 1'b1, pend_c_r, 1'b1)
                                 : mk_out(1'b1, 1'b0, '0, 1'b1);
            state_nxt = S_IDLE;
          end
        end else if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            emit      = 1'b1;
            emit_item = mk_out(1'b1, 1'b1, pend_c_r, 1'b0);
          end
          pend_v_nxt = 1'b1;
          pend_c_nxt = ram_rdata;
          cnt_nxt    = cnt_inc;
          if (scan_r == wp_r || cnt_inc == CNT_LIMIT) begin
            state_nxt = S_STR_LAST;
          end else begin
            scan_nxt  = step_addr;
            ram_re    = 1'b1;
            ram_raddr = step_addr;
          end
        end
      end

      S_STR_LAST: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = mk_out(1'b1, 1'b1, pend_c_r, 1'b1);
          state_nxt = S_IDLE;
        end
      end

      S_FAIL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = mk_out(1'b0, 1'b0, '0, 1'b1);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_item_nxt = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      ulen_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      ulen_r      <= ulen_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    steps_r    <= steps_nxt;
    cnt_r      <= cnt_nxt;
    pend_c_r   <= pend_c_nxt;
    char_r     <= char_nxt;
    out_item_r <= out_item_nxt;
  end

  a_ulen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ulen_r <= ULEN_FULL)
    else $error("used length beyond store depth");

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (ulen_r != '0) |-> ({1'b0, wp_r} < ulen_r && {1'b0, rp_r} < ulen_r))
    else $error("pointer outside used part of ring");

  a_write_only_append: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_APP_CHAR || state_r == S_APP_SEP))
    else $error("history write during recall");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.has_char) |-> out_item_r.last)
    else $error("result without character not marked last");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("pending result overwritten");

endmodule

FILE: bench/tb_line_history_ring.sv
// Self-checking testbench for line_history_ring: predicts every recall and compares results.
`timescale 1ns / 1ps
module tb_line_history_ring import lhr_pkg::*; ();

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 2_000_000;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         TAIL_CYCLES = 800;
  localparam int         HOLD_CYCLES = 400;
  localparam lhr_out_t   NO_STRING    = {1'b0, 1'b0, 8'h00, 1'b1};
  localparam lhr_out_t   EMPTY_STRING = {1'b1, 1'b0, 8'h00, 1'b1};

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  lhr_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  lhr_out_t out_item;

  char_t      hist_bytes [HIST_DEPTH];
  bit         hist_written [HIST_DEPTH];
  hist_addr_t wr_ptr;
  hist_addr_t rd_ptr;
  ulen_t      used_len;
  bit         touched_unwritten;
  lhr_out_t   recall_burst [$];
  lhr_out_t   pending_results [$];
  lhr_out_t   oldest_result;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int mismatches;
  int cycle_count;

  line_history_ring dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int ring_next(int x);
    return (x + 1) % int'(used_len);
  endfunction

  function automatic int ring_prev(int x);
    return (x + int'(used_len) - 1) % int'(used_len);
  endfunction

  function automatic char_t peek_byte(int idx);
    if (!hist_written[idx % HIST_DEPTH]) touched_unwritten = 1'b1;
    return hist_bytes[idx % HIST_DEPTH];
  endfunction

  function automatic void put_byte(int idx, char_t c);
    hist_bytes[idx] = c;
    hist_written[idx] = 1'b1;
  endfunction

  function automatic void stream_string();
    int    r;
    int    count;
    char_t c;
    r = int'(rd_ptr);
    count = 0;
    while (count < RECALL_LIMIT) begin
      c = peek_byte(r);
      if (c == 8'h00) break;
      recall_burst.push_back(lhr_out_t'({1'b1, 1'b1, c, 1'b0}));
      count++;
      if (r == int'(wr_ptr)) break;
      r = ring_next(r);
    end
    if (count == 0) recall_burst.push_back(EMPTY_STRING);
    else recall_burst[count - 1].last = 1'b1;
  endfunction

  // Model one item and flag a read of a history byte never written; commit keeps its effect and results.
  function automatic bit history_step(lhr_in_t item, bit commit);
    hist_addr_t saved_rd;
    int         n;
    int         steps;
    bit         moved;
    saved_rd = rd_ptr;
    touched_unwritten = 1'b0;
    moved = 1'b0;
    n = 0;
    recall_burst.delete();
    case (item.op)
      OP_APPEND: begin
        if (commit) begin
          if (used_len == 0) begin
            put_byte(0, 8'h00);
            wr_ptr = hist_addr_t'(1);
            rd_ptr = wr_ptr;
          end
          put_byte(int'(wr_ptr), item.char_in);
          n = int'(wr_ptr) + 1;
          if (used_len < ULEN_FULL) begin
            used_len = ulen_t'((n + 1 > HIST_DEPTH) ? HIST_DEPTH : n + 1);
          end
          wr_ptr = hist_addr_t'(n % HIST_DEPTH);
          if (item.char_in == 8'h00) begin
            rd_ptr = wr_ptr;
            put_byte(int'(wr_ptr), 8'h00);
          end
        end
      end
      OP_PREV: begin
        if (used_len != 0) begin
          n = ring_prev(int'(rd_ptr) % int'(used_len));
          steps = 0;
          while (steps < int'(used_len)) begin
            steps++;
            n = ring_prev(n);
            if (n == int'(wr_ptr)) break;
            if (peek_byte(n) == 8'h00) begin
              moved = 1'b1;
              break;
            end
          end
        end
        if (moved) rd_ptr = hist_addr_t'(ring_next(n));
      end
      OP_NEXT: begin
        if (used_len != 0 && rd_ptr != wr_ptr) begin
          n = int'(rd_ptr) % int'(used_len);
          steps = 0;
          moved = 1'b1;
          while (peek_byte(n) != 8'h00) begin
            if (steps >= int'(used_len)) begin
              moved = 1'b0;
              break;
            end
            steps++;
            n = ring_next(n);
          end
        end
        if (moved) rd_ptr = hist_addr_t'(ring_next(n));
      end
      default: ;
    endcase
    if (item.op == OP_PREV || item.op == OP_NEXT) begin
      if (moved) stream_string();
      else recall_burst.push_back(NO_STRING);
    end
    if (commit) begin
      foreach (recall_burst[i]) pending_results.push_back(recall_burst[i]);
    end else begin
      rd_ptr = saved_rd;
    end
    return touched_unwritten;
  endfunction

  function automatic logic [1:0] random_recall_op();
    return ($urandom_range(0, 1) == 1) ? OP_PREV : OP_NEXT;
  endfunction

  task automatic send_item(lhr_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(history_step(item, 1'b1));
    @(negedge clk);
  endtask

  task automatic send_char(char_t c);
    send_item({OP_APPEND, c});
  endtask

  // Drop a recall that would read history never written.
  task automatic send_recall(logic [1:0] op);
    lhr_in_t item;
    item = {op, char_t'($urandom_range(0, 255))};
    if (!history_step(item, 1'b0)) send_item(item);
  endtask

  task automatic send_text(int len, bit terminate);
    repeat (len) send_char(char_t'($urandom_range(1, 255)));
    if (terminate) send_char(8'h00);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_empty_history();
    send_recall(OP_PREV);
    send_recall(OP_NEXT);
    send_item({OP_UNUSED, 8'hA5});
  endtask

  task automatic test_directed_strings();
    char_t extremes [6];
    extremes = '{8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    foreach (extremes[i]) send_char(extremes[i]);
    send_char(8'h00);
    send_text(2, 1'b1);
    send_char(8'h00);
    repeat (4) send_recall(OP_PREV);
    repeat (3) send_recall(OP_NEXT);
    send_char(8'h71);
    send_recall(OP_PREV);
    send_recall(OP_NEXT);
    send_char(8'h00);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 10);
        send_text(len, 1'b1);
        sent += len + 1;
      end else if (pick < 85) begin
        len = $urandom_range(1, 4);
        repeat (len) send_recall(random_recall_op());
        sent += len;
      end else if (pick < 92) begin
        send_item({OP_UNUSED, char_t'($urandom_range(0, 255))});
        sent++;
      end else begin
        len = $urandom_range(1, 5);
        send_text(len, 1'b0);
        send_recall(random_recall_op());
        sent += len + 1;
      end
    end
  endtask

  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    send_text(70, 1'b1);
    repeat (3) begin
      send_recall(OP_PREV);
      send_recall(OP_NEXT);
    end
    send_text(3, 1'b1);
    send_recall(OP_PREV);
    wait_results_drained();
  endtask

  task automatic test_ring_wrap();
    int         len;
    bit         wrapped;
    hist_addr_t last_wr;
    wrapped = 1'b0;
    while (!wrapped) begin
      last_wr = wr_ptr;
      len = $urandom_range(5, 30);
      send_text(len, 1'b1);
      if (wr_ptr < last_wr) wrapped = 1'b1;
      if ($urandom_range(0, 3) == 0) send_recall(random_recall_op());
    end
    repeat (8) send_recall(random_recall_op());
    send_text(20, 1'b0);
    send_recall(OP_PREV);
    send_recall(OP_NEXT);
    send_char(8'h00);
    send_recall(OP_PREV);
    send_recall(OP_NEXT);
    send_recall(OP_PREV);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got found/has_char/char_out/last %b/%b/%02h/%b",
                 $time, out_item.found, out_item.has_char, out_item.char_out, out_item.last);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.found !== oldest_result.found ||
            out_item.has_char !== oldest_result.has_char ||
            out_item.char_out !== oldest_result.char_out ||
            out_item.last !== oldest_result.last) begin
          $display("%0t: found/has_char/char_out/last expected %b/%b/%02h/%b, got %b/%b/%02h/%b",
                   $time, oldest_result.found, oldest_result.has_char,
                   oldest_result.char_out, oldest_result.last,
                   out_item.found, out_item.has_char, out_item.char_out, out_item.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    wr_ptr   = '0;
    rd_ptr   = '0;
    used_len = '0;
    send_idle_pct = 19;
    recv_idle_pct = 53;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_history();
    test_directed_strings();
    test_random_traffic(15);
    wait_results_drained();
    send_idle_pct = 53;
    recv_idle_pct = 19;
    test_random_traffic(15);
    wait_results_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(15);
    test_output_backpressure();
    test_ring_wrap();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
